@@ hw/rtl/ckb_pkg.sv @@
// Shared types, constants and helpers for the colour-keyed sprite blitter.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package ckb_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int DIM_W      = $clog2(MAX_DIM);
	localparam int REG_W      = 13;
	localparam int KEY_W      = 17;
	localparam int PIX_W      = 16;
	localparam int ADDR_W     = 24;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_WIDE_PIXELS   = 3'd2,
		REG_SPRITE_WIDTH  = 3'd3,
		REG_SPRITE_HEIGHT = 3'd4,
		REG_ORIGIN_X      = 3'd5,
		REG_ORIGIN_Y      = 3'd6,
		REG_KEY_COLOR     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [REG_W-1:0] screen_width;
		logic [REG_W-1:0] screen_height;
		logic             wide_pixels;
		logic [REG_W-1:0] sprite_width;
		logic [REG_W-1:0] sprite_height;
		logic [REG_W-1:0] origin_x;
		logic [REG_W-1:0] origin_y;
		logic [KEY_W-1:0] key_color;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] row;
		logic             sprite_end;
	} item_t;

	// last index along a sprite dimension: size 0 acts as 1, oversize as MAX_DIM
	function automatic logic [DIM_W-1:0] last_pos(input logic [REG_W-1:0] size);
		logic [REG_W-1:0] dec;
		dec = size - REG_W'(1);
		if (size == '0)
			return '0;
		else if (size > REG_W'(MAX_DIM))
			return DIM_W'(MAX_DIM - 1);
		else
			return dec[DIM_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ckb_cfg.sv @@
// Configuration register bank for the sprite blitter.
// Depends on ckb_pkg.
`default_nettype none

module ckb_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ckb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ckb_pkg::CFG_DATA_W-1:0] cfg_data,
	output ckb_pkg::cfg_t                       cfg
);

	ckb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= ckb_pkg::REG_W'(640);
			cfg_q.screen_height <= ckb_pkg::REG_W'(480);
			cfg_q.wide_pixels   <= 1'b1;
			cfg_q.sprite_width  <= ckb_pkg::REG_W'(1);
			cfg_q.sprite_height <= ckb_pkg::REG_W'(1);
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
			cfg_q.key_color     <= '1;
		end else if (cfg_we) begin
			case (ckb_pkg::reg_idx_t'(cfg_index))
				ckb_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[ckb_pkg::REG_W-1:0];
				ckb_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[ckb_pkg::REG_W-1:0];
				ckb_pkg::REG_WIDE_PIXELS:   cfg_q.wide_pixels   <= cfg_data[0];
				ckb_pkg::REG_SPRITE_WIDTH:  cfg_q.sprite_width  <= cfg_data[ckb_pkg::REG_W-1:0];
				ckb_pkg::REG_SPRITE_HEIGHT: cfg_q.sprite_height <= cfg_data[ckb_pkg::REG_W-1:0];
				ckb_pkg::REG_ORIGIN_X:      cfg_q.origin_x      <= cfg_data[ckb_pkg::REG_W-1:0];
				ckb_pkg::REG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_data[ckb_pkg::REG_W-1:0];
				ckb_pkg::REG_KEY_COLOR:     cfg_q.key_color     <= cfg_data[ckb_pkg::KEY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/ckb_walk.sv @@
// Raster walker: sprite column/row counters and the input stage register.
// Depends on ckb_pkg.
`default_nettype none

module ckb_walk (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ckb_pkg::cfg_t             cfg,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [ckb_pkg::PIX_W-1:0] pixel_value,
	input  wire logic                      s2_load,
	output logic                           valid_s1,
	output ckb_pkg::item_t                 item_s1
);

	logic [ckb_pkg::DIM_W-1:0] col_q, row_q;
	logic [ckb_pkg::DIM_W-1:0] last_col, last_row, col_eff, row_eff;
	logic                      at_last_col, at_last_row, take;

	assign last_col    = ckb_pkg::last_pos(cfg.sprite_width);
	assign last_row    = ckb_pkg::last_pos(cfg.sprite_height);
	// counters past a shrunk size sit at the last position
	assign col_eff     = (col_q > last_col) ? last_col : col_q;
	assign row_eff     = (row_q > last_row) ? last_row : row_q;
	assign at_last_col = (col_eff == last_col);
	assign at_last_row = (row_eff == last_row);

	assign in_ready = !valid_s1 || s2_load;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (take) begin
				if (at_last_col) begin
					col_q <= '0;
					row_q <= at_last_row ? '0 : row_eff + ckb_pkg::DIM_W'(1);
				end else begin
					col_q <= col_eff + ckb_pkg::DIM_W'(1);
					row_q <= row_eff;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.pixel      <= pixel_value;
			item_s1.col        <= col_eff;
			item_s1.row        <= row_eff;
			item_s1.sprite_end <= at_last_col && at_last_row;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ckb_place.sv @@
// Placement, clipping, keying and address generation; holds the result register.
// Depends on ckb_pkg.
`default_nettype none

module ckb_place (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ckb_pkg::cfg_t              cfg,
	input  wire logic                       valid_s1,
	input  wire ckb_pkg::item_t             item_s1,
	output logic                            s2_load,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            write_enable,
	output logic [ckb_pkg::ADDR_W-1:0]      write_address,
	output logic [ckb_pkg::PIX_W-1:0]       write_data,
	output logic                            sprite_end
);

	localparam int POS_W = ckb_pkg::REG_W + 1;

	logic [POS_W-1:0]               sx, sy;
	logic [2*ckb_pkg::REG_W-1:0]    prod;
	logic [ckb_pkg::ADDR_W-1:0]     addr;
	logic [ckb_pkg::PIX_W-1:0]      pix;
	logic                           visible, keyed, we;

	// signed origin plus unsigned counter, two's complement
	assign sx = {cfg.origin_x[ckb_pkg::REG_W-1], cfg.origin_x}
		+ POS_W'(item_s1.col);
	assign sy = {cfg.origin_y[ckb_pkg::REG_W-1], cfg.origin_y}
		+ POS_W'(item_s1.row);

	assign visible = !sx[POS_W-1] && !sy[POS_W-1]
		&& (sx[ckb_pkg::REG_W-1:0] < cfg.screen_width)
		&& (sy[ckb_pkg::REG_W-1:0] < cfg.screen_height);

	assign pix = cfg.wide_pixels ? item_s1.pixel
		: {8'h00, item_s1.pixel[7:0]};

	assign keyed = !cfg.key_color[ckb_pkg::KEY_W-1]
		&& (cfg.key_color[ckb_pkg::PIX_W-1:0] == pix);

	assign we   = visible && !keyed;
	assign prod = sy[ckb_pkg::REG_W-1:0] * cfg.screen_width;
	assign addr = prod[ckb_pkg::ADDR_W-1:0] + ckb_pkg::ADDR_W'(sx[ckb_pkg::REG_W-1:0]);

	assign s2_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (s2_load)
			out_valid <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			write_enable  <= we;
			write_address <= we ? addr : '0;
			write_data    <= we ? pix : '0;
			sprite_end    <= item_s1.sprite_end;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/color_key_sprite_blit.sv @@
// Colour-keyed sprite blitter with screen clipping: top level.
// Pipeline: a request is registered in the walker stage, then in the result register.
// Throughput: one request per cycle while out_ready is high, set by both stages.
// Reset: counters at the sprite's first pixel, both stages empty, registers
// 640, 480, 16-bit, 1x1 sprite, origin 0,0, keying disabled.
// Depends on ckb_pkg, ckb_cfg, ckb_walk, ckb_place.
`default_nettype none

module color_key_sprite_blit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ckb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ckb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [ckb_pkg::PIX_W-1:0]      pixel_value,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                write_enable,
	output logic [ckb_pkg::ADDR_W-1:0]          write_address,
	output logic [ckb_pkg::PIX_W-1:0]           write_data,
	output logic                                sprite_end
);

	ckb_pkg::cfg_t  cfg;
	ckb_pkg::item_t item_s1;
	logic           valid_s1, s2_load;

	ckb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ckb_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_value (pixel_value),
		.s2_load     (s2_load),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1)
	);

	ckb_place u_place (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.s2_load       (s2_load),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_enable  (write_enable),
		.write_address (write_address),
		.write_data    (write_data),
		.sprite_end    (sprite_end)
	);

	a_quiet_when_skipped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> write_address == '0 && write_data == '0)
		else $error("suppressed write carries address or data");

	a_narrow_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cfg.wide_pixels |-> write_data[15:8] == 8'h00)
		else $error("upper byte set in 8-bit mode");

	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && s2_load |=> out_valid)
		else $error("stage one request lost");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking bench for color_key_sprite_blit: directed and random pixel requests,
// predicted writes checked in order against the result channel.
// Depends on ckb_pkg and the color_key_sprite_blit RTL.
`default_nettype none

module tb_top;

	typedef struct {
		logic                       we;
		logic [ckb_pkg::ADDR_W-1:0] addr;
		logic [ckb_pkg::PIX_W-1:0]  data;
		logic                       send;
	} blit_wr_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [ckb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ckb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [ckb_pkg::PIX_W-1:0]      pixel_value = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           write_enable;
	logic [ckb_pkg::ADDR_W-1:0]     write_address;
	logic [ckb_pkg::PIX_W-1:0]      write_data;
	logic                           sprite_end;

	color_key_sprite_blit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pixel_value   (pixel_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_enable  (write_enable),
		.write_address (write_address),
		.write_data    (write_data),
		.sprite_end    (sprite_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// register shadow and sprite position
	logic [ckb_pkg::REG_W-1:0] scr_w = 13'd640, scr_h = 13'd480;
	logic                      wide = 1'b1;
	logic [ckb_pkg::REG_W-1:0] spr_w = 13'd1, spr_h = 13'd1;
	logic [ckb_pkg::REG_W-1:0] org_x = '0, org_y = '0;
	logic [ckb_pkg::KEY_W-1:0] key_col = '1;
	logic [ckb_pkg::DIM_W-1:0] spr_col = '0, spr_row = '0;

	logic [ckb_pkg::PIX_W-1:0] pixel_q[$];
	blit_wr_t                  wr_expect_q[$];
	blit_wr_t                  head_wr;
	int                        pending = 0;
	int                        errors = 0;
	int                        sent = 0;
	int                        in_gap = 0;
	int                        stall_left = 0;
	bit                        calm = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ckb_pkg::DIM_W-1:0] dim_last(
			input logic [ckb_pkg::REG_W-1:0] size);
		if (size == '0)
			return '0;
		if (size > ckb_pkg::REG_W'(ckb_pkg::MAX_DIM))
			return ckb_pkg::DIM_W'(ckb_pkg::MAX_DIM - 1);
		return ckb_pkg::DIM_W'(size - 13'd1);
	endfunction

	function automatic blit_wr_t blit_predict(input logic [ckb_pkg::PIX_W-1:0] pv);
		blit_wr_t                  r;
		logic [ckb_pkg::DIM_W-1:0] lc, lr;
		logic [ckb_pkg::PIX_W-1:0] pix;
		logic [31:0]               a;
		int                        sx, sy;
		bit                        vis, keyed;
		lc = dim_last(spr_w);
		lr = dim_last(spr_h);
		pix = wide ? pv : {8'h00, pv[7:0]};
		if (spr_col > lc)
			spr_col = lc;
		if (spr_row > lr)
			spr_row = lr;
		sx = int'($signed(org_x));
		sx = sx + int'(spr_col);
		sy = int'($signed(org_y));
		sy = sy + int'(spr_row);
		vis = sx >= 0 && sy >= 0 && sx < int'(scr_w) && sy < int'(scr_h);
		keyed = !key_col[ckb_pkg::KEY_W-1] && key_col[ckb_pkg::PIX_W-1:0] == pix;
		a = 32'(sy) * 32'(scr_w) + 32'(sx);
		r.we = vis && !keyed;
		r.addr = r.we ? a[ckb_pkg::ADDR_W-1:0] : '0;
		r.data = r.we ? pix : '0;
		r.send = spr_col == lc && spr_row == lr;
		if (spr_col == lc) begin
			spr_col = '0;
			spr_row = (spr_row == lr) ? '0 : spr_row + 1'b1;
		end else begin
			spr_col = spr_col + 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				wr_expect_q.push_back(blit_predict(pixel_value));
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					in_valid <= 1'b1;
					pixel_value <= pixel_q.pop_front();
					in_gap = calm ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (wr_expect_q.size() == 0) begin
					report_mismatch("result with none expected", 32'(write_address), 0);
				end else begin
					head_wr = wr_expect_q.pop_front();
					if (write_enable !== head_wr.we)
						report_mismatch("write_enable", 32'(write_enable),
							32'(head_wr.we));
					if (write_address !== head_wr.addr)
						report_mismatch("write_address", 32'(write_address),
							32'(head_wr.addr));
					if (write_data !== head_wr.data)
						report_mismatch("write_data", 32'(write_data),
							32'(head_wr.data));
					if (sprite_end !== head_wr.send)
						report_mismatch("sprite_end", 32'(sprite_end),
							32'(head_wr.send));
					pending--;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = calm ? 0 : pick_gap();
			end
		end
	end

	task automatic cfg_write(input ckb_pkg::reg_idx_t idx,
			input logic [ckb_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			ckb_pkg::REG_SCREEN_WIDTH:  scr_w = val[ckb_pkg::REG_W-1:0];
			ckb_pkg::REG_SCREEN_HEIGHT: scr_h = val[ckb_pkg::REG_W-1:0];
			ckb_pkg::REG_WIDE_PIXELS:   wide = val[0];
			ckb_pkg::REG_SPRITE_WIDTH:  spr_w = val[ckb_pkg::REG_W-1:0];
			ckb_pkg::REG_SPRITE_HEIGHT: spr_h = val[ckb_pkg::REG_W-1:0];
			ckb_pkg::REG_ORIGIN_X:      org_x = val[ckb_pkg::REG_W-1:0];
			ckb_pkg::REG_ORIGIN_Y:      org_y = val[ckb_pkg::REG_W-1:0];
			ckb_pkg::REG_KEY_COLOR:     key_col = val[ckb_pkg::KEY_W-1:0];
			default: ;
		endcase
	endtask

	task automatic cfg_done();
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [ckb_pkg::PIX_W-1:0] v);
		pixel_q.push_back(v);
		pending++;
		sent++;
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [ckb_pkg::REG_W-1:0] rand_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 13'd1;
			2: return 13'h1FFF;
			3: return ckb_pkg::REG_W'(ckb_pkg::MAX_DIM);
			4: return ckb_pkg::REG_W'($urandom);
			default: return ckb_pkg::REG_W'($urandom_range(1, 24));
		endcase
	endfunction

	function automatic logic [ckb_pkg::REG_W-1:0] rand_origin();
		case ($urandom_range(0, 6))
			0: return 13'h1000;
			1: return 13'h0FFF;
			2: return ckb_pkg::REG_W'($urandom);
			default: return ckb_pkg::REG_W'($urandom_range(0, 40)) - 13'd20;
		endcase
	endfunction

	function automatic logic [ckb_pkg::KEY_W-1:0] rand_key();
		case ($urandom_range(0, 5))
			0: return '1;
			1: return {1'b0, 16'($urandom)};
			2: return ckb_pkg::KEY_W'($urandom_range(0, 255));
			3: return ckb_pkg::KEY_W'($urandom);
			default: return ckb_pkg::KEY_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [ckb_pkg::PIX_W-1:0] rand_pixel();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return key_col[ckb_pkg::PIX_W-1:0]
				| (wide ? 16'h0000 : 16'($urandom) & 16'hFF00);
		if (r == 2)
			return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		return ckb_pkg::PIX_W'($urandom);
	endfunction

	initial begin
		int n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: 1x1 sprite at the origin, keying off
		send_pixel(16'h0000);
		send_pixel(16'hFFFF);
		send_pixel(16'h8001);
		drain();

		// 8-bit mode, sprite hanging off top-left, key matched on the low byte only
		cfg_write(ckb_pkg::REG_SCREEN_WIDTH, 17'd16);
		cfg_write(ckb_pkg::REG_SCREEN_HEIGHT, 17'd8);
		cfg_write(ckb_pkg::REG_WIDE_PIXELS, 17'd0);
		cfg_write(ckb_pkg::REG_SPRITE_WIDTH, 17'd4);
		cfg_write(ckb_pkg::REG_SPRITE_HEIGHT, 17'd3);
		cfg_write(ckb_pkg::REG_ORIGIN_X, 17'h01FFE);
		cfg_write(ckb_pkg::REG_ORIGIN_Y, 17'h01FFF);
		cfg_write(ckb_pkg::REG_KEY_COLOR, 17'h000AB);
		cfg_done();
		send_pixel(16'h00AB);
		send_pixel(16'h12AB);
		send_pixel(16'hFFFF);
		send_pixel(16'h0000);
		send_pixel(16'h5A3C);
		send_pixel(16'hABAB);
		send_pixel(16'h00AA);
		send_pixel(16'h8000);
		send_pixel(16'h7FFF);
		send_pixel(16'h0001);
		send_pixel(16'h00FF);
		send_pixel(16'hFF00);
		drain();

		// zero sprite size, pixel at the bottom-right corner, 16-bit key
		cfg_write(ckb_pkg::REG_WIDE_PIXELS, 17'd1);
		cfg_write(ckb_pkg::REG_KEY_COLOR, 17'h0FFFF);
		cfg_write(ckb_pkg::REG_SPRITE_WIDTH, 17'd0);
		cfg_write(ckb_pkg::REG_SPRITE_HEIGHT, 17'd0);
		cfg_write(ckb_pkg::REG_ORIGIN_X, 17'd15);
		cfg_write(ckb_pkg::REG_ORIGIN_Y, 17'd7);
		cfg_done();
		send_pixel(16'hFFFF);
		send_pixel(16'h1234);
		drain();

		// empty screen
		cfg_write(ckb_pkg::REG_SCREEN_WIDTH, 17'd0);
		cfg_done();
		send_pixel(16'h4321);
		drain();

		// far corner, address wraps
		cfg_write(ckb_pkg::REG_SCREEN_WIDTH, 17'h01FFF);
		cfg_write(ckb_pkg::REG_SCREEN_HEIGHT, 17'h01FFF);
		cfg_write(ckb_pkg::REG_SPRITE_WIDTH, 17'h01FFF);
		cfg_write(ckb_pkg::REG_SPRITE_HEIGHT, 17'd2);
		cfg_write(ckb_pkg::REG_ORIGIN_X, 17'h00FFF);
		cfg_write(ckb_pkg::REG_ORIGIN_Y, 17'h00FFF);
		cfg_done();
		send_pixel(16'h0F0F);
		send_pixel(16'hF0F0);
		drain();
		cfg_write(ckb_pkg::REG_ORIGIN_X, 17'h01000);
		cfg_write(ckb_pkg::REG_ORIGIN_Y, 17'h01000);
		cfg_done();
		send_pixel(16'h2222);
		drain();

		// shrink mid-sprite: column beyond new width
		cfg_write(ckb_pkg::REG_SPRITE_WIDTH, 17'd2);
		cfg_write(ckb_pkg::REG_ORIGIN_X, 17'd0);
		cfg_write(ckb_pkg::REG_ORIGIN_Y, 17'd0);
		cfg_done();
		send_pixel(16'h3333);
		send_pixel(16'h4444);
		drain();

		// negative key other than -1
		cfg_write(ckb_pkg::REG_KEY_COLOR, 17'h10000);
		cfg_done();
		send_pixel(16'h0000);
		drain();

		while (sent < 830) begin
			if ($urandom_range(0, 5) == 0) begin
				cfg_write(ckb_pkg::REG_SCREEN_WIDTH, 17'($urandom_range(4097, 8191)));
				cfg_write(ckb_pkg::REG_SCREEN_HEIGHT, 17'h01FFF);
				cfg_write(ckb_pkg::REG_ORIGIN_Y, 17'($urandom_range(3000, 4095)));
				cfg_write(ckb_pkg::REG_ORIGIN_X,
					17'(ckb_pkg::REG_W'($urandom_range(0, 100)) - 13'd8));
			end else begin
				if ($urandom_range(0, 9) < 7)
					cfg_write(ckb_pkg::REG_SCREEN_WIDTH, 17'(rand_size()));
				if ($urandom_range(0, 9) < 7)
					cfg_write(ckb_pkg::REG_SCREEN_HEIGHT, 17'(rand_size()));
				if ($urandom_range(0, 9) < 7)
					cfg_write(ckb_pkg::REG_ORIGIN_X, 17'(rand_origin()));
				if ($urandom_range(0, 9) < 7)
					cfg_write(ckb_pkg::REG_ORIGIN_Y, 17'(rand_origin()));
			end
			if ($urandom_range(0, 9) < 7)
				cfg_write(ckb_pkg::REG_SPRITE_WIDTH, 17'(rand_size()));
			if ($urandom_range(0, 9) < 7)
				cfg_write(ckb_pkg::REG_SPRITE_HEIGHT, 17'(rand_size()));
			if ($urandom_range(0, 9) < 5)
				cfg_write(ckb_pkg::REG_WIDE_PIXELS, 17'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) < 7)
				cfg_write(ckb_pkg::REG_KEY_COLOR, rand_key());
			cfg_done();
			calm = ($urandom_range(0, 4) == 0);
			n = $urandom_range(10, 60);
			repeat (n)
				send_pixel(rand_pixel());
			drain();
		end

		repeat (8) @(posedge clk);
		if (errors == 0 && wr_expect_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

@@ color_key_sprite_blit.f @@
hw/rtl/ckb_pkg.sv
hw/rtl/ckb_cfg.sv
hw/rtl/ckb_walk.sv
hw/rtl/ckb_place.sv
hw/rtl/color_key_sprite_blit.sv
tb/sv/tb_top.sv
